@@ hw/rtl/tlpte_pkg.sv @@
// Shared constants and codes for the two-level page table engine.
`timescale 1ns / 1ps
`default_nettype none
package tlpte_pkg;

	// Directory and table geometry (both indexed by ten address bits)
	localparam int IDX_W          = 10;
	localparam int DIR_SIZE       = 1024;
	localparam int TBL_SIZE       = 1024;
	localparam int OFF_W          = 12;
	localparam int NUM_TABLES_DEF = 8;

	// Address field widths and packing of the stream words
	localparam int ADDR_W     = 32;
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;
	localparam int CODE_W     = 2;

	localparam logic [ADDR_W-1:0] FRAME_MASK = 32'hFFFF_F000;
	localparam logic [ADDR_W-1:0] ALL_ONES   = 32'hFFFF_FFFF;

	// Operation codes
	localparam logic [CODE_W-1:0] MODE_MAP   = 2'd0;
	localparam logic [CODE_W-1:0] MODE_UNMAP = 2'd1;
	localparam logic [CODE_W-1:0] MODE_XLATE = 2'd2;
	localparam logic [CODE_W-1:0] MODE_NONE  = 2'd3;

	// Result status codes
	localparam logic [CODE_W-1:0] STAT_OK       = 2'd0;
	localparam logic [CODE_W-1:0] STAT_MISALIGN = 2'd1;
	localparam logic [CODE_W-1:0] STAT_NO_TABLE = 2'd2;
	localparam logic [CODE_W-1:0] STAT_UNMAPPED = 2'd3;

endpackage
`default_nettype wire

@@ hw/rtl/tlpte_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tlpte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire                                 clk,
	input  wire                                 we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire [WIDTH-1:0]                     wdata,
	output logic [WIDTH-1:0]                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on enable, otherwise read into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/two_level_page_table_engine_core.sv @@
// Top level of the two-level page table engine: sequencer around directory and table RAMs.
//
// Usage: requests enter on the s_axis channel (mode in tuser; virtual address,
// physical address and flags in tdata) and one result word leaves on the
// m_axis channel per request (status in tuser, translated address in tdata).
// A word is taken at a clock edge where tvalid and tready are both high.
// Requests are handled one at a time by a small sequencer that reads the
// directory RAM, then reads or writes the table RAM (both with registered
// read data). Map, unmap and the unused mode finish in the directory step
// (S_DIR); translate goes on to a table step (S_TBL) that reads the entry.
// A map that allocates a fresh table sweeps its 1024 entries to zero, one
// per cycle, and then writes the new mapping.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls with the output register full, a finished
// result is parked and the sequencer holds until the register drains.
// After arst_n is released the directory is cleared by a sweep of its 1024
// entries, one entry per cycle, during which s_axis_tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module two_level_page_table_engine_core
	import tlpte_pkg::*;
#(
	parameter int NUM_TABLES = NUM_TABLES_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	// request: tdata {flags[75:64], phys_addr[63:32], virt_addr[31:0]}, zero pad to 80
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire [IN_DATA_W-1:0]   s_axis_tdata,
	// request: tuser {mode[1:0]}
	input  wire [CODE_W-1:0]      s_axis_tuser,
	// result: tdata {phys_out[31:0]}
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// result: tuser {status[1:0]}
	output logic [CODE_W-1:0]     m_axis_tuser
);

	localparam int TW     = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int UW     = $clog2(NUM_TABLES + 1);
	localparam int DW     = TW + 1;
	localparam int TBL_D  = NUM_TABLES * TBL_SIZE;
	localparam int TBL_AW = (TBL_D > 1) ? $clog2(TBL_D) : 1;

	// Sequencer states
	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_DIR   = 3'd2;
	localparam logic [2:0] S_TBL   = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_WMAP  = 3'd5;
	localparam logic [2:0] S_HOLD  = 3'd6;

	logic [2:0]        state_q, state_d;
	logic [IDX_W-1:0]  cnt_q;
	logic [UW-1:0]     used_q;
	logic [TW-1:0]     tnum_q;
	logic [CODE_W-1:0] mode_q;
	logic [ADDR_W-1:0] va_q, pa_q;
	logic [OFF_W-1:0]  flg_q;
	logic [CODE_W-1:0] hold_stat_q;
	logic [ADDR_W-1:0] hold_phys_q;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_stat_q;
	logic [ADDR_W-1:0] out_phys_q;

	logic              dir_we;
	logic [IDX_W-1:0]  dir_addr;
	logic [DW-1:0]     dir_wdata, dir_rdata;
	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_addr;
	logic [ADDR_W-1:0] tbl_wdata, tbl_rdata;

	logic              res_fire;
	logic [CODE_W-1:0] res_stat;
	logic [ADDR_W-1:0] res_phys;
	logic              alloc;
	logic              in_acc;
	logic              out_free;
	logic              dir_pres;
	logic [TW-1:0]     dir_t;
	logic [TW-1:0]     new_t;
	logic              misal;
	logic              pool_full;
	logic [IDX_W-1:0]  slot, idx;
	logic [ADDR_W-1:0] map_word;

	assign in_acc    = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;
	assign dir_pres  = dir_rdata[TW];
	assign dir_t     = dir_rdata[TW-1:0];
	assign new_t     = used_q[TW-1:0];
	assign misal     = |(va_q[OFF_W-1:0] | pa_q[OFF_W-1:0]);
	assign pool_full = (used_q == UW'(NUM_TABLES));
	assign slot      = va_q[ADDR_W-1 -: IDX_W];
	assign idx       = va_q[OFF_W +: IDX_W];
	assign map_word  = (pa_q & FRAME_MASK) | {{(ADDR_W-OFF_W){1'b0}}, flg_q} | 32'd1;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_phys_q;
	assign m_axis_tuser  = out_stat_q;

	tlpte_ram #(.WIDTH(DW), .DEPTH(DIR_SIZE)) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.addr  (dir_addr),
		.wdata (dir_wdata),
		.rdata (dir_rdata)
	);

	tlpte_ram #(.WIDTH(ADDR_W), .DEPTH(TBL_D)) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.addr  (tbl_addr),
		.wdata (tbl_wdata),
		.rdata (tbl_rdata)
	);

	// Decode the current step: memory accesses, result and next state
	always_comb begin
		state_d   = state_q;
		dir_we    = 1'b0;
		dir_addr  = s_axis_tdata[ADDR_W-1 -: IDX_W];
		dir_wdata = '0;
		tbl_we    = 1'b0;
		tbl_addr  = TBL_AW'({dir_t, idx});
		tbl_wdata = '0;
		res_fire  = 1'b0;
		res_stat  = STAT_OK;
		res_phys  = '0;
		alloc     = 1'b0;
		unique case (state_q)
			S_CLR: begin
				dir_we   = 1'b1;
				dir_addr = cnt_q;
				if (&cnt_q) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_acc) begin
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				dir_addr = slot;
				unique case (mode_q)
					MODE_MAP: begin
						if (misal) begin
							res_fire = 1'b1;
							res_stat = STAT_MISALIGN;
						end else if (dir_pres) begin
							tbl_we    = 1'b1;
							tbl_wdata = map_word;
							res_fire  = 1'b1;
						end else if (pool_full) begin
							res_fire = 1'b1;
							res_stat = STAT_NO_TABLE;
						end else begin
							dir_we    = 1'b1;
							dir_wdata = {1'b1, new_t};
							alloc     = 1'b1;
							state_d   = S_SWEEP;
						end
					end
					MODE_UNMAP: begin
						res_fire = 1'b1;
						if (dir_pres) begin
							tbl_we = 1'b1;
						end else begin
							res_stat = STAT_UNMAPPED;
						end
					end
					MODE_XLATE: begin
						if (dir_pres) begin
							state_d = S_TBL;
						end else begin
							res_fire = 1'b1;
							res_stat = STAT_UNMAPPED;
							res_phys = ALL_ONES;
						end
					end
					MODE_NONE: begin
						res_fire = 1'b1;
					end
				endcase
			end
			S_TBL: begin
				res_fire = 1'b1;
				if (tbl_rdata[0]) begin
					res_phys = (tbl_rdata & FRAME_MASK) |
						{{(ADDR_W-OFF_W){1'b0}}, va_q[OFF_W-1:0]};
				end else begin
					res_stat = STAT_UNMAPPED;
					res_phys = ALL_ONES;
				end
			end
			S_SWEEP: begin
				tbl_we   = 1'b1;
				tbl_addr = TBL_AW'({tnum_q, cnt_q});
				if (&cnt_q) begin
					state_d = S_WMAP;
				end
			end
			S_WMAP: begin
				tbl_we    = 1'b1;
				tbl_addr  = TBL_AW'({tnum_q, idx});
				tbl_wdata = map_word;
				res_fire  = 1'b1;
			end
			S_HOLD: begin
				res_fire = 1'b1;
				res_stat = hold_stat_q;
				res_phys = hold_phys_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (res_fire) begin
			state_d = out_free ? S_IDLE : S_HOLD;
		end
	end

	// Advance sequencer, counters and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			cnt_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR || state_q == S_SWEEP) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (alloc) begin
				cnt_q <= '0;
			end
			if (alloc) begin
				used_q <= used_q + 1'b1;
			end
			if (res_fire && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture request, parked result and output payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= s_axis_tuser;
			va_q   <= s_axis_tdata[ADDR_W-1:0];
			pa_q   <= s_axis_tdata[2*ADDR_W-1:ADDR_W];
			flg_q  <= s_axis_tdata[2*ADDR_W +: OFF_W];
		end
		if (alloc) begin
			tnum_q <= new_t;
		end
		if (res_fire && !out_free) begin
			hold_stat_q <= res_stat;
			hold_phys_q <= res_phys;
		end
		if (res_fire && out_free) begin
			out_stat_q <= res_stat;
			out_phys_q <= res_phys;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/tlpte_checker.sv @@
// Port-level checker for the page table engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tlpte_checker
	import tlpte_pkg::*;
(
	input wire                  clk,
	input wire                  arst_n,
	input wire                  s_axis_tvalid,
	input wire                  s_axis_tready,
	input wire [IN_DATA_W-1:0]  s_axis_tdata,
	input wire [CODE_W-1:0]     s_axis_tuser,
	input wire                  m_axis_tvalid,
	input wire                  m_axis_tready,
	input wire [OUT_DATA_W-1:0] m_axis_tdata,
	input wire [CODE_W-1:0]     m_axis_tuser
);

	// A stalled result word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	// One request at a time: no acceptance right after an acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while the previous one is in work");

	// A new result appears only while the engine is busy with a request
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !$past(s_axis_tready))
		else $error("result word without a request in work");

	// Map failures carry a zero address
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == STAT_MISALIGN || m_axis_tuser == STAT_NO_TABLE)
		|-> m_axis_tdata == '0)
		else $error("failed map returned a nonzero address");

endmodule

bind two_level_page_table_engine_core tlpte_checker u_tlpte_checker (.*);
`default_nettype wire
